>>> hw/rtl/swbe_pkg.sv
package swbe_pkg;

	localparam int unsigned DATA_W = 64;
	localparam int unsigned SW_W   = 48;

	// action codes
	localparam logic [1:0] ACT_ACC_FIRST  = 2'd0;
	localparam logic [1:0] ACT_ACC_SECOND = 2'd1;
	localparam logic [1:0] ACT_FINALIZE   = 2'd2;
	localparam logic [1:0] ACT_NONE       = 2'd3;

	// register indexes
	localparam logic [1:0] REG_GRAV_X = 2'd0;
	localparam logic [1:0] REG_GRAV_Y = 2'd1;
	localparam logic [1:0] REG_GRAV_Z = 2'd2;

	typedef struct packed {
		logic [SW_W-1:0]          sw;
		logic [DATA_W-1:0]        sp;
		logic [2:0][DATA_W-1:0]   sdd;
		logic [2:0][DATA_W-1:0]   svw;
	} row_t;

	function automatic logic [63:0] mag64(input logic [63:0] v);
		mag64 = v[63] ? (64'd0 - v) : v;
	endfunction

	function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63])
			sat_add64 = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		else
			sat_add64 = s;
	endfunction

	function automatic logic [31:0] sat32(input logic [63:0] v);
		if (!v[63] && v[62:31] != 32'd0)
			sat32 = {1'b0, {31{1'b1}}};
		else if (v[63] && v[62:31] != {32{1'b1}})
			sat32 = {1'b1, 31'd0};
		else
			sat32 = v[31:0];
	endfunction

endpackage

>>> hw/rtl/sph_wall_boundary_extrapolation.sv
// Channel   | Handshake                  | Ports
// ----------+----------------------------+------------------------------------------
// request   | start & !busy              | action, wall_index, weight, nb_*, vec_a_*,
//           |                            | separation, vel_*
// result    | done (one cycle, no stall) | out_index, has_neighbours, wall_pressure,
//           |                            | wall_vel_x/y/z
// config    | psel & penable & pwrite    | paddr, pwdata, prdata, pready (always 1)
//
// After reset the table is swept to zero, one row a cycle, with busy high (config writes
// are still taken). Busy steps per request: accumulate does a row read, load, nine
// multiplies on the shared multiplier and a row write; finalize does three multiplies
// and four divides; finalize of an empty entry only reads, loads and writes the row.
// done rises, for finalize requests only, in the same cycle that busy drops.
// A result request is shown for one cycle with done; the receiver cannot stall it.
// Ignored requests (action 3, index out of range) leave the block idle at once.
module sph_wall_boundary_extrapolation #(
	parameter int WALL_PARTICLES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	// config
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// request
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         action,
	input  logic [9:0]         wall_index,
	input  logic [30:0]        weight,
	input  logic signed [31:0] nb_pressure,
	input  logic [30:0]        nb_density,
	input  logic [30:0]        separation,
	input  logic signed [31:0] vec_a_x,
	input  logic signed [31:0] vec_a_y,
	input  logic signed [31:0] vec_a_z,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic signed [31:0] vel_z,
	// result
	output logic               done,
	output logic [9:0]         out_index,
	output logic               has_neighbours,
	output logic signed [31:0] wall_pressure,
	output logic signed [31:0] wall_vel_x,
	output logic signed [31:0] wall_vel_y,
	output logic signed [31:0] wall_vel_z
);

	localparam int AW = $clog2(WALL_PARTICLES);
	localparam int RW = $bits(swbe_pkg::row_t);

	// multiply steps: accumulate uses 0..8, finalize 9..11
	localparam logic [3:0] OP_DR   = 4'd0;
	localparam logic [3:0] OP_FW   = 4'd1;
	localparam logic [3:0] OP_PW   = 4'd2;
	localparam logic [3:0] OP_DD0  = 4'd3;
	localparam logic [3:0] OP_DD1  = 4'd4;
	localparam logic [3:0] OP_DD2  = 4'd5;
	localparam logic [3:0] OP_VW0  = 4'd6;
	localparam logic [3:0] OP_VW1  = 4'd7;
	localparam logic [3:0] OP_VW2  = 4'd8;
	localparam logic [3:0] OP_GD0  = 4'd9;
	localparam logic [3:0] OP_GD1  = 4'd10;
	localparam logic [3:0] OP_GD2  = 4'd11;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_READ, S_LOAD, S_MGO, S_MWAIT, S_DGO, S_DWAIT, S_WRITE
	} state_t;

	state_t state_q;

	// gravity registers
	logic [2:0][31:0] grav_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				swbe_pkg::REG_GRAV_X: grav_q[0] <= pwdata;
				swbe_pkg::REG_GRAV_Y: grav_q[1] <= pwdata;
				swbe_pkg::REG_GRAV_Z: grav_q[2] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			swbe_pkg::REG_GRAV_X: prdata = grav_q[0];
			swbe_pkg::REG_GRAV_Y: prdata = grav_q[1];
			swbe_pkg::REG_GRAV_Z: prdata = grav_q[2];
			default:              prdata = '0;
		endcase
	end

	// latched request
	logic [1:0]       act_q;
	logic [30:0]      w_q, d_q, r_q;
	logic [31:0]      p_q;
	logic [2:0][31:0] vec_q, vel_q;
	logic [AW-1:0]    addr_q, clr_q;
	logic [3:0]       op_q;
	logic [1:0]       dv_q;
	logic [63:0]      t_q, fac_q;
	swbe_pkg::row_t   row_q, rdata;
	logic             fin;

	assign fin  = (act_q == swbe_pkg::ACT_FINALIZE);
	assign busy = (state_q != S_IDLE);

	// table
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [RW-1:0] ram_wdata, ram_rdata;
	logic [48:0]   sw_sum;
	swbe_pkg::row_t row_upd;

	assign sw_sum = {1'b0, row_q.sw} + 49'(w_q);
	always_comb begin
		row_upd    = row_q;
		row_upd.sw = sw_sum[48] ? {48{1'b1}} : sw_sum[47:0];
	end

	assign ram_we    = (state_q == S_CLEAR) || (state_q == S_WRITE);
	assign ram_waddr = (state_q == S_CLEAR) ? clr_q : addr_q;
	assign ram_wdata = (state_q == S_WRITE && !fin) ? row_upd : '0;
	assign rdata     = ram_rdata;

	swbe_ram #(.WIDTH(RW), .DEPTH(WALL_PARTICLES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	// shared multiplier operand select
	logic [1:0]  kk;
	logic [63:0] ma, mb;
	logic        mneg, mul_start, mul_done;
	logic [63:0] mul_res;
	logic [32:0] gdiff;

	always_comb begin
		case (op_q)
			OP_DD0, OP_VW0, OP_GD0: kk = 2'd0;
			OP_DD1, OP_VW1, OP_GD1: kk = 2'd1;
			default:                kk = 2'd2;
		endcase
	end

	assign gdiff = {grav_q[kk][31], grav_q[kk]} - {vec_q[kk][31], vec_q[kk]};

	always_comb begin
		ma   = 64'(d_q);
		mb   = 64'(r_q);
		mneg = 1'b0;
		case (op_q)
			OP_DR: ;
			OP_FW: begin
				ma = t_q;
				mb = 64'(w_q);
			end
			OP_PW: begin
				ma   = swbe_pkg::mag64({{32{p_q[31]}}, p_q});
				mb   = 64'(w_q);
				mneg = p_q[31];
			end
			OP_DD0, OP_DD1, OP_DD2: begin
				ma   = fac_q;
				mb   = swbe_pkg::mag64({{32{vec_q[kk][31]}}, vec_q[kk]});
				mneg = (act_q == swbe_pkg::ACT_ACC_SECOND) ^ vec_q[kk][31];
			end
			OP_VW0, OP_VW1, OP_VW2: begin
				ma   = 64'(w_q);
				mb   = swbe_pkg::mag64({{32{vel_q[kk][31]}}, vel_q[kk]});
				mneg = vel_q[kk][31];
			end
			OP_GD0, OP_GD1, OP_GD2: begin
				ma   = swbe_pkg::mag64({{31{gdiff[32]}}, gdiff});
				mb   = swbe_pkg::mag64(row_q.sdd[kk]);
				mneg = gdiff[32] ^ row_q.sdd[kk][63];
			end
			default: ;
		endcase
	end

	assign mul_start = (state_q == S_MGO);

	swbe_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a_mag  (ma),
		.b_mag  (mb),
		.neg    (mneg),
		.done   (mul_done),
		.res    (mul_res)
	);

	// shared divider
	logic [1:0]  vk;
	logic [63:0] dnum;
	logic        div_start, div_done;
	logic [41:0] div_res;
	logic [63:0] vout;

	assign vk        = dv_q - 2'd1;
	assign dnum      = (dv_q == 2'd0) ? row_q.sp : row_q.svw[vk];
	assign div_start = (state_q == S_DGO);
	// 2v - V/W; fits 64 bits without overflow
	assign vout      = ({{32{vel_q[vk][31]}}, vel_q[vk]} <<< 1) -
	                   {{22{div_res[41]}}, div_res};

	swbe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (dnum),
		.den    (row_q.sw),
		.done   (div_done),
		.res    (div_res)
	);

	logic idx_ok;
	assign idx_ok = (32'(wall_index) < 32'(WALL_PARTICLES));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_q          <= '0;
			done           <= 1'b0;
			has_neighbours <= 1'b0;
			op_q           <= '0;
			dv_q           <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(WALL_PARTICLES - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start && action != swbe_pkg::ACT_NONE && idx_ok) begin
						act_q     <= action;
						addr_q    <= AW'(wall_index);
						out_index <= wall_index;
						w_q       <= weight;
						p_q       <= nb_pressure;
						d_q       <= nb_density;
						r_q       <= separation;
						vec_q     <= {vec_a_z, vec_a_y, vec_a_x};
						vel_q     <= {vel_z, vel_y, vel_x};
						state_q   <= S_READ;
					end
				end
				S_READ: state_q <= S_LOAD;
				S_LOAD: begin
					row_q <= rdata;
					if (fin) begin
						has_neighbours <= (rdata.sw != '0);
						wall_pressure  <= '0;
						wall_vel_x     <= '0;
						wall_vel_y     <= '0;
						wall_vel_z     <= '0;
						op_q           <= OP_GD0;
						state_q        <= (rdata.sw != '0) ? S_MGO : S_WRITE;
					end else begin
						op_q    <= OP_DR;
						state_q <= S_MGO;
					end
				end
				S_MGO: state_q <= S_MWAIT;
				S_MWAIT: begin
					if (mul_done) begin
						case (op_q)
							OP_DR:              t_q <= mul_res;
							OP_FW:              fac_q <= mul_res;
							OP_PW, OP_GD0, OP_GD1, OP_GD2:
								row_q.sp <= swbe_pkg::sat_add64(row_q.sp, mul_res);
							OP_DD0, OP_DD1, OP_DD2:
								row_q.sdd[kk] <= swbe_pkg::sat_add64(row_q.sdd[kk], mul_res);
							OP_VW0, OP_VW1, OP_VW2:
								row_q.svw[kk] <= swbe_pkg::sat_add64(row_q.svw[kk], mul_res);
							default: ;
						endcase
						if (op_q == OP_VW2) begin
							state_q <= S_WRITE;
						end else if (op_q == OP_GD2) begin
							dv_q    <= '0;
							state_q <= S_DGO;
						end else begin
							op_q    <= op_q + 4'd1;
							state_q <= S_MGO;
						end
					end
				end
				S_DGO: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (div_done) begin
						case (dv_q)
							2'd0: wall_pressure <= swbe_pkg::sat32({{22{div_res[41]}}, div_res});
							2'd1: wall_vel_x    <= swbe_pkg::sat32(vout);
							2'd2: wall_vel_y    <= swbe_pkg::sat32(vout);
							default: wall_vel_z <= swbe_pkg::sat32(vout);
						endcase
						if (dv_q == 2'd3) begin
							state_q <= S_WRITE;
						end else begin
							dv_q    <= dv_q + 2'd1;
							state_q <= S_DGO;
						end
					end
				end
				S_WRITE: begin
					done    <= fin;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !has_neighbours |-> wall_pressure == 0 && wall_vel_x == 0 &&
		wall_vel_y == 0 && wall_vel_z == 0) else $error("empty entry gave nonzero result");
	a_idle_units: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !mul_done && !div_done) else $error("arithmetic unit active while idle");
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !ram_we) else $error("table written while idle");
`endif

endmodule

>>> hw/rtl/swbe_ram.sv
module swbe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/swbe_mul.sv
// Q16.16 sign-magnitude multiply, 32x32 partial products, one per cycle.
module swbe_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a_mag,
	input  logic [63:0] b_mag,
	input  logic        neg,
	output logic        done,
	output logic [63:0] res
);

	logic [63:0]  a_q, b_q, pp_q;
	logic         neg_q, run_q;
	logic [2:0]   cnt_q;
	logic [1:0]   psh_q;
	logic [127:0] acc_q;
	logic [31:0]  xa, xb;
	logic [63:0]  mag;

	assign xa = cnt_q[1] ? a_q[63:32] : a_q[31:0];
	assign xb = cnt_q[0] ? b_q[63:32] : b_q[31:0];

	always_comb begin
		mag = (acc_q[127:80] != 48'd0) ? {64{1'b1}} : acc_q[79:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				a_q   <= a_mag;
				b_q   <= b_mag;
				neg_q <= neg;
				acc_q <= '0;
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (!cnt_q[2]) begin
					pp_q  <= xa * xb;
					psh_q <= 2'(cnt_q[1]) + 2'(cnt_q[0]);
				end
				if (cnt_q != 3'd0 && cnt_q != 3'd5) begin
					acc_q <= acc_q + (128'(pp_q) << (7'd32 * 7'(psh_q)));
				end
				if (cnt_q == 3'd5) begin
					run_q <= 1'b0;
					done  <= 1'b1;
					if (neg_q)
						res <= mag[63] ? {1'b1, 63'd0} : (64'd0 - mag);
					else
						res <= mag[63] ? {1'b0, {63{1'b1}}} : mag;
				end
			end
		end
	end

endmodule

>>> hw/rtl/swbe_div.sv
// (num << 16) / den, restoring, one quotient bit per cycle; magnitude clamped to 2^40.
module swbe_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [47:0] den,
	output logic        done,
	output logic [41:0] res
);

	logic [79:0] dvd_q, quo_q;
	logic [47:0] den_q, rem_q;
	logic        neg_q, run_q;
	logic [6:0]  cnt_q;
	logic [48:0] trial;
	logic        qbit;
	logic [40:0] qmag;

	assign trial = {rem_q, dvd_q[79]};
	assign qbit  = (trial >= {1'b0, den_q});
	assign qmag  = (quo_q[79:40] != 40'd0) ? {1'b1, 40'd0} : quo_q[40:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				dvd_q <= {swbe_pkg::mag64(num), 16'd0};
				neg_q <= num[63];
				den_q <= den;
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				if (cnt_q != 7'd80) begin
					cnt_q <= cnt_q + 7'd1;
					dvd_q <= {dvd_q[78:0], 1'b0};
					quo_q <= {quo_q[78:0], qbit};
					rem_q <= qbit ? 48'(trial - {1'b0, den_q}) : trial[47:0];
				end else begin
					run_q <= 1'b0;
					done  <= 1'b1;
					res   <= neg_q ? (42'd0 - {1'b0, qmag}) : {1'b0, qmag};
				end
			end
		end
	end

endmodule
